// ===== src/bscf_pkg.sv =====
package bscf_pkg;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;

   localparam logic [ACTION_W-1:0] ACT_TEST  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SET   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [COUNT_W-1:0] BITS_IN_USE_RESET = 11'd1024;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_LOC,
      ST_MOD,
      ST_SCAN,
      ST_FIN
   } bscf_state_type;

   typedef struct packed {
      logic start;
      logic take;
   } bscf_scan_ctl_type;

endpackage

// ===== src/bscf_map_mem.sv =====
module bscf_map_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bscf_scan.sv =====
module bscf_scan #(
   parameter int WORD_BITS = 32,
   parameter int BASE_W    = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bscf_pkg::bscf_scan_ctl_type     ctl,
   input  logic [WORD_BITS-1:0]            word,
   input  logic [bscf_pkg::COUNT_W-1:0]    lim,
   output logic [bscf_pkg::INDEX_W-1:0]    zero_index,
   output logic                            zero_found,
   output logic [bscf_pkg::INDEX_W-1:0]    one_index,
   output logic                            one_found
);

   localparam int PW = $clog2(WORD_BITS);
   localparam int EW = ((BASE_W > bscf_pkg::COUNT_W) ? BASE_W : bscf_pkg::COUNT_W) + 1;

   logic [BASE_W-1:0]            base_ff, base_in;
   logic                         zf_ff, zf_in, of_ff, of_in;
   logic [bscf_pkg::INDEX_W-1:0] zi_ff, zi_in, oi_ff, oi_in;

   logic [EW-1:0]        lim_e, base_e, left;
   logic                 live;
   logic [WORD_BITS-1:0] in_use, zc, oc;
   logic [PW-1:0]        zpos, opos;

   always_comb begin
      lim_e  = EW'(lim);
      base_e = EW'(base_ff);
      live   = lim_e > base_e;
      left   = lim_e - base_e;
      for (int b = 0; b < WORD_BITS; b++) begin
         in_use[b] = live && (left > EW'(b));
         zc[b]     = in_use[b] & ~word[b];
         oc[b]     = in_use[b] & word[b];
      end
      zpos = '0;
      opos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (zc[b]) begin
            zpos = PW'(b);
         end
         if (oc[b]) begin
            opos = PW'(b);
         end
      end
   end

   always_comb begin
      base_in = base_ff;
      zf_in   = zf_ff;
      of_in   = of_ff;
      zi_in   = zi_ff;
      oi_in   = oi_ff;
      if (ctl.start) begin
         base_in = '0;
         zf_in   = 1'b0;
         of_in   = 1'b0;
         zi_in   = '0;
         oi_in   = '0;
      end else if (ctl.take) begin
         base_in = base_ff + BASE_W'(WORD_BITS);
         if (!zf_ff && (|zc)) begin
            zf_in = 1'b1;
            zi_in = bscf_pkg::INDEX_W'(base_ff + BASE_W'(zpos));
         end
         if (!of_ff && (|oc)) begin
            of_in = 1'b1;
            oi_in = bscf_pkg::INDEX_W'(base_ff + BASE_W'(opos));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zf_ff <= 1'b0;
         of_ff <= 1'b0;
      end else begin
         zf_ff <= zf_in;
         of_ff <= of_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      zi_ff   <= zi_in;
      oi_ff   <= oi_in;
   end

   assign zero_index = zi_ff;
   assign zero_found = zf_ff;
   assign one_index  = oi_ff;
   assign one_found  = of_ff;

endmodule

// ===== src/bitmap_set_clear_find_first.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_action, req_bit_index
// rsp       out        rsp_valid/rsp_stall  bit_was_set, index_error, first zero/one + found
// csr       in         csr_wr_en            csr_wr_data (bits_in_use)
//
// Once an item is taken, the block divides the index, locates the word, reads it and, for a
// set or clear with no index error, writes it back; then it reads every map word once through
// the single read port and loads the result. No new item is taken until the result is
// loaded; req_stall is high outside the idle state.
// After reset a clearing pass writes zero to all WORD_COUNT words, one word a cycle.
// A finished item waits in the output register; the search end holds while it is full and rsp_stall is high.
module bitmap_set_clear_find_first #(
   parameter int MAP_BITS  = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bscf_pkg::ACTION_W-1:0]    req_action,
   input  logic [bscf_pkg::INDEX_W-1:0]     req_bit_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_bit_was_set,
   output logic                             rsp_index_error,
   output logic [bscf_pkg::INDEX_W-1:0]     rsp_first_zero_index,
   output logic                             rsp_first_zero_found,
   output logic [bscf_pkg::INDEX_W-1:0]     rsp_first_one_index,
   output logic                             rsp_first_one_found,
   input  logic                             csr_wr_en,
   input  logic [bscf_pkg::COUNT_W-1:0]     csr_wr_data
);

   localparam int WORD_COUNT  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW          = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int CW          = $clog2(WORD_COUNT + 1);
   localparam int PW          = $clog2(WORD_BITS);
   localparam int BW          = $clog2(WORD_COUNT * WORD_BITS + 1);
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BITS;
   localparam int PROD_W      = bscf_pkg::INDEX_W + RECIP_SHIFT;
   localparam int LOC_W       = bscf_pkg::INDEX_W + 1;

   bscf_pkg::bscf_state_type state_ff, state_in;

   logic [CW-1:0]                     cnt_ff, cnt_in;
   logic [bscf_pkg::ACTION_W-1:0]     action_ff, action_in;
   logic [bscf_pkg::INDEX_W-1:0]      pos_ff, pos_in;
   logic [bscf_pkg::INDEX_W-1:0]      q_ff, q_in;
   logic [AW-1:0]                     waddr_ff, waddr_in;
   logic [PW-1:0]                     bit_ff, bit_in;
   logic                              err_ff, err_in;
   logic                              was_ff, was_in;
   logic [bscf_pkg::COUNT_W-1:0]      csr_bits_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_was_ff, rsp_was_in;
   logic                              rsp_err_ff, rsp_err_in;
   logic [bscf_pkg::INDEX_W-1:0]      rsp_zi_ff, rsp_zi_in, rsp_oi_ff, rsp_oi_in;
   logic                              rsp_zf_ff, rsp_zf_in, rsp_of_ff, rsp_of_in;

   logic [bscf_pkg::COUNT_W-1:0]      lim;
   logic [PROD_W-1:0]                 prod;
   logic [LOC_W-1:0]                  qm, rem;
   logic [AW-1:0]                     loc_addr;
   logic [PW-1:0]                     loc_bit;
   logic [WORD_BITS-1:0]              new_word, bit_mask;

   logic                              mem_wr_en, mem_rd_en;
   logic [AW-1:0]                     mem_wr_addr, mem_rd_addr;
   logic [WORD_BITS-1:0]              mem_wr_data, mem_rd_data;

   bscf_pkg::bscf_scan_ctl_type       scan_ctl;
   logic [bscf_pkg::INDEX_W-1:0]      scan_zi, scan_oi;
   logic                              scan_zf, scan_of;

   bscf_map_mem #(
      .DEPTH (WORD_COUNT),
      .WIDTH (WORD_BITS),
      .AW    (AW)
   ) u_map_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bscf_scan #(
      .WORD_BITS (WORD_BITS),
      .BASE_W    (BW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .word       (mem_rd_data),
      .lim        (lim),
      .zero_index (scan_zi),
      .zero_found (scan_zf),
      .one_index  (scan_oi),
      .one_found  (scan_of)
   );

   always_comb begin
      if (32'(csr_bits_ff) > 32'(MAP_BITS)) begin
         lim = bscf_pkg::COUNT_W'(MAP_BITS);
      end else begin
         lim = csr_bits_ff;
      end
      prod = PROD_W'(pos_ff) * PROD_W'(RECIP);
      qm   = LOC_W'(q_ff * WORD_BITS);
      rem  = LOC_W'(pos_ff) - qm;
      if (rem >= LOC_W'(WORD_BITS)) begin
         loc_addr = AW'(q_ff + bscf_pkg::INDEX_W'(1));
         loc_bit  = PW'(rem - LOC_W'(WORD_BITS));
      end else begin
         loc_addr = AW'(q_ff);
         loc_bit  = PW'(rem);
      end
      bit_mask = WORD_BITS'(1) << bit_ff;
      if (action_ff == bscf_pkg::ACT_SET) begin
         new_word = mem_rd_data | bit_mask;
      end else begin
         new_word = mem_rd_data & ~bit_mask;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      action_in    = action_ff;
      pos_in       = pos_ff;
      q_in         = q_ff;
      waddr_in     = waddr_ff;
      bit_in       = bit_ff;
      err_in       = err_ff;
      was_in       = was_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_was_in   = rsp_was_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_zi_in    = rsp_zi_ff;
      rsp_zf_in    = rsp_zf_ff;
      rsp_oi_in    = rsp_oi_ff;
      rsp_of_in    = rsp_of_ff;
      req_stall    = 1'b1;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = waddr_ff;
      mem_wr_data  = new_word;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = AW'(cnt_ff);
      scan_ctl     = '0;

      unique case (state_ff)
         bscf_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(cnt_ff);
            mem_wr_data = '0;
            if (cnt_ff == CW'(WORD_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = bscf_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         bscf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               action_in = req_action;
               pos_in    = req_bit_index;
               state_in  = bscf_pkg::ST_DIV;
            end
         end
         bscf_pkg::ST_DIV: begin
            q_in     = bscf_pkg::INDEX_W'(prod >> RECIP_SHIFT);
            state_in = bscf_pkg::ST_LOC;
         end
         bscf_pkg::ST_LOC: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = loc_addr;
            waddr_in    = loc_addr;
            bit_in      = loc_bit;
            err_in      = LOC_W'(pos_ff) >= lim;
            state_in    = bscf_pkg::ST_MOD;
         end
         bscf_pkg::ST_MOD: begin
            was_in    = !err_ff && mem_rd_data[bit_ff];
            mem_wr_en = !err_ff && ((action_ff == bscf_pkg::ACT_SET) ||
                                    (action_ff == bscf_pkg::ACT_CLEAR));
            scan_ctl.start = 1'b1;
            cnt_in   = '0;
            state_in = bscf_pkg::ST_SCAN;
         end
         bscf_pkg::ST_SCAN: begin
            mem_rd_en     = cnt_ff != CW'(WORD_COUNT);
            scan_ctl.take = cnt_ff != '0;
            if (cnt_ff == CW'(WORD_COUNT)) begin
               cnt_in   = '0;
               state_in = bscf_pkg::ST_FIN;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         bscf_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_was_in   = was_ff;
               rsp_err_in   = err_ff;
               rsp_zi_in    = scan_zi;
               rsp_zf_in    = scan_zf;
               rsp_oi_in    = scan_oi;
               rsp_of_in    = scan_of;
               state_in     = bscf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bscf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bscf_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         csr_bits_ff  <= bscf_pkg::BITS_IN_USE_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_bits_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      pos_ff     <= pos_in;
      q_ff       <= q_in;
      waddr_ff   <= waddr_in;
      bit_ff     <= bit_in;
      err_ff     <= err_in;
      was_ff     <= was_in;
      rsp_was_ff <= rsp_was_in;
      rsp_err_ff <= rsp_err_in;
      rsp_zi_ff  <= rsp_zi_in;
      rsp_zf_ff  <= rsp_zf_in;
      rsp_oi_ff  <= rsp_oi_in;
      rsp_of_ff  <= rsp_of_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bit_was_set      = rsp_was_ff;
   assign rsp_index_error      = rsp_err_ff;
   assign rsp_first_zero_index = rsp_zi_ff;
   assign rsp_first_zero_found = rsp_zf_ff;
   assign rsp_first_one_index  = rsp_oi_ff;
   assign rsp_first_one_found  = rsp_of_ff;

endmodule
